// ===== sv/svpwm_pkg.sv =====
// Shared constants and types of the space vector PWM timing block.
`default_nettype none

package svpwm_pkg;

	// Operand widths of the datapath.
	localparam int MAG_W   = 16;
	localparam int SUMSQ_W = 32;
	localparam int A_W     = 31;
	localparam int SIN_W   = 31;
	localparam int P_W     = 32;
	localparam int Q_W     = 33;
	localparam int X_W     = 49;

	// Q30 constants: pi/3, sqrt(3) and one.
	localparam logic [30:0] PI3_Q30   = 31'd1124419809;
	localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

	// Sine series: divisors 72, 42, 20 and 6 as exact reciprocal multiplies.
	localparam int POLY_STEPS = 4;
	localparam logic [31:0] POLY_RECIP [POLY_STEPS] = '{
		32'd3817748708, 32'd3272356036, 32'd3435973837, 32'd2863311531
	};
	localparam int POLY_SHIFT [POLY_STEPS] = '{38, 37, 36, 34};

	// Pipeline depths of the arithmetic units.
	localparam int SIN_LAT     = 11;
	localparam int SQRT_STAGES = 8;
	localparam int DIV_BPS     = 4;
	localparam int DIV_STAGES  = 13;
	localparam int DIV_W       = DIV_BPS * DIV_STAGES;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_DC_LINK     = 2'd0,
		REG_MAX_MAG     = 2'd1,
		REG_HALF_PERIOD = 2'd2
	} reg_index_t;

	// Register values after reset.
	localparam logic [15:0] DC_LINK_RESET     = 16'd32767;
	localparam logic [15:0] MAX_MAG_RESET     = 16'd18918;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd4200;

endpackage

`default_nettype wire

// ===== sv/svpwm_queue.sv =====
// Short queue that decouples the front end from the arithmetic back end.
`default_nettype none

module svpwm_queue #(
	parameter int W     = 45,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              afull,
	output logic              head_valid,
	output logic [W-1:0]      head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	// The back end never stalls, so the head is taken whenever it exists.
	assign head_valid = (count_q != '0);
	assign pop        = head_valid;
	assign head_data  = mem_q[rd_ptr_q];
	assign afull      = (count_q >= CW'(DEPTH - 1));

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/svpwm_front.sv =====
// Front end: takes an item, finds its sector and sine index and the squared magnitude.
`default_nettype none

module svpwm_front import svpwm_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int ANGLE_BITS      = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [15:0]                theta,
	input  wire logic signed [15:0]         alpha_voltage,
	input  wire logic signed [15:0]         beta_voltage,
	input  wire logic                       queue_afull,
	output logic                            push,
	output logic [2:0]                      push_sector,
	output logic [SINE_TABLE_BITS-1:0]      push_k,
	output logic [SUMSQ_W-1:0]              push_sumsq
);
	localparam int AB = ANGLE_BITS;
	localparam int SB = SINE_TABLE_BITS;

	logic                accept;
	logic [AB-1:0]       theta_m;
	logic [AB+2:0]       six;
	logic [AB-1:0]       u;
	logic [SB-1:0]       k;
	logic signed [31:0]  sqa;
	logic signed [31:0]  sqb;

	logic                valid_s1;
	logic [2:0]          sector_s1;
	logic [SB-1:0]       k_s1;
	logic [30:0]         sqa_s1;
	logic [30:0]         sqb_s1;

	assign busy   = queue_afull;
	assign accept = start && !busy;

	// Angle times six: the top bits are the sector, the rest the position in it.
	assign theta_m = AB'(theta);
	assign six     = (AB + 3)'({theta_m, 2'b00}) + (AB + 3)'({theta_m, 1'b0});
	assign u       = six[AB-1:0];

	generate
		if (AB >= SB) begin : g_k_trunc
			assign k = u[AB-1 -: SB];
		end else begin : g_k_widen
			assign k = {u, {(SB - AB){1'b0}}};
		end
	endgenerate

	// Squares of the two voltage components.
	assign sqa = alpha_voltage * alpha_voltage;
	assign sqb = beta_voltage * beta_voltage;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sector_s1 <= six[AB+2:AB];
			k_s1      <= k;
			sqa_s1    <= sqa[30:0];
			sqb_s1    <= sqb[30:0];
		end
	end

	// Transfer into the queue in the cycle after acceptance.
	assign push        = valid_s1;
	assign push_sector = sector_s1;
	assign push_k      = k_s1;
	assign push_sumsq  = {1'b0, sqa_s1} + {1'b0, sqb_s1};

endmodule

`default_nettype wire

// ===== sv/svpwm_sine.sv =====
// Pipelined sine of an angle within one sector, by a short Taylor series.
`default_nettype none

module svpwm_sine import svpwm_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                     clk,
	input  wire logic [SINE_TABLE_BITS:0] k,
	output logic [SIN_W-1:0]              sine
);
	localparam int KW = SINE_TABLE_BITS + 1;
	localparam int PW = A_W + KW;

	logic [PW-1:0]      prod_a;
	logic [2*A_W-1:0]   sq_a;
	logic [2*A_W-1:0]   prod_s;
	logic [A_W-1:0]     a_s1;
	logic [A_W-1:0]     a_s2;
	logic [A_W-1:0]     a2_s2;
	logic [A_W-1:0]     a_sm  [POLY_STEPS];
	logic [A_W-1:0]     a2_sm [POLY_STEPS];
	logic [A_W-1:0]     m_sm  [POLY_STEPS];
	logic [A_W-1:0]     a_sh  [POLY_STEPS];
	logic [A_W-1:0]     a2_sh [POLY_STEPS];
	logic [A_W-1:0]     h_sh  [POLY_STEPS];
	logic [SIN_W-1:0]   sine_s11;

	// Angle in Q30 radians, then its square.
	assign prod_a = PW'(PI3_Q30) * PW'(k);
	assign sq_a   = (2 * A_W)'(a_s1) * (2 * A_W)'(a_s1);

	always_ff @(posedge clk) begin
		a_s1  <= A_W'(prod_a >> SINE_TABLE_BITS);
		a_s2  <= a_s1;
		a2_s2 <= A_W'(sq_a >> 30);
	end

	// Horner steps: h = 1 - a^2 * h / c, each a multiply stage and a divide stage.
	generate
		for (genvar i = 0; i < POLY_STEPS; i++) begin : g_poly
			logic [A_W-1:0]     a_in;
			logic [A_W-1:0]     a2_in;
			logic [A_W-1:0]     h_in;
			logic [2*A_W-1:0]   mul;
			logic [63:0]        rmul;

			if (i == 0) begin : g_first
				assign a_in  = a_s2;
				assign a2_in = a2_s2;
				assign h_in  = Q30_ONE;
			end else begin : g_next
				assign a_in  = a_sh[i-1];
				assign a2_in = a2_sh[i-1];
				assign h_in  = h_sh[i-1];
			end

			assign mul  = (2 * A_W)'(a2_in) * (2 * A_W)'(h_in);
			assign rmul = 64'(m_sm[i]) * 64'(POLY_RECIP[i]);

			always_ff @(posedge clk) begin
				a_sm[i]  <= a_in;
				a2_sm[i] <= a2_in;
				m_sm[i]  <= A_W'(mul >> 30);
				a_sh[i]  <= a_sm[i];
				a2_sh[i] <= a2_sm[i];
				h_sh[i]  <= Q30_ONE - A_W'(rmul >> POLY_SHIFT[i]);
			end
		end
	endgenerate

	// Final product a * h.
	assign prod_s = (2 * A_W)'(a_sh[POLY_STEPS-1]) * (2 * A_W)'(h_sh[POLY_STEPS-1]);

	always_ff @(posedge clk) begin
		sine_s11 <= SIN_W'(prod_s >> 30);
	end

	assign sine = sine_s11;

endmodule

`default_nettype wire

// ===== sv/svpwm_div.sv =====
// Pipelined restoring divider, a few quotient bits per stage.
`default_nettype none

module svpwm_div import svpwm_pkg::*; (
	input  wire logic             clk,
	input  wire logic [X_W-1:0]   dividend,
	input  wire logic [15:0]      divisor,
	output logic [X_W-1:0]        quotient
);
	logic [DIV_W-1:0] word_s [DIV_STAGES];
	logic [15:0]      rem_s  [DIV_STAGES];

	generate
		for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
			logic [DIV_W-1:0] word_in;
			logic [15:0]      rem_in;
			logic [DIV_W-1:0] word_nx;
			logic [15:0]      rem_nx;

			if (j == 0) begin : g_first
				assign word_in = DIV_W'(dividend);
				assign rem_in  = '0;
			end else begin : g_next
				assign word_in = word_s[j-1];
				assign rem_in  = rem_s[j-1];
			end

			// Shift in dividend bits, subtract where the divisor fits.
			always_comb begin : div_step
				logic [16:0]      r;
				logic [DIV_W-1:0] w;
				r = {1'b0, rem_in};
				w = word_in;
				for (int b = 0; b < DIV_BPS; b++) begin
					r = {r[15:0], w[DIV_W-1]};
					w = {w[DIV_W-2:0], 1'b0};
					if (r >= {1'b0, divisor}) begin
						r    = r - {1'b0, divisor};
						w[0] = 1'b1;
					end
				end
				rem_nx  = r[15:0];
				word_nx = w;
			end

			always_ff @(posedge clk) begin
				word_s[j] <= word_nx;
				rem_s[j]  <= rem_nx;
			end
		end
	endgenerate

	assign quotient = X_W'(word_s[DIV_STAGES-1]);

endmodule

`default_nettype wire

// ===== sv/svpwm_back.sv =====
// Back end: magnitude, dwell times, zero-vector split and per-sector compare values.
`default_nettype none

module svpwm_back import svpwm_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire logic [2:0]                  head_sector,
	input  wire logic [SINE_TABLE_BITS-1:0]  head_k,
	input  wire logic [SUMSQ_W-1:0]          head_sumsq,
	input  wire logic [15:0]                 udc,
	input  wire logic [15:0]                 max_ref_magnitude,
	input  wire logic [15:0]                 half_period_ticks,
	output logic                             done,
	output logic [15:0]                      compare_a,
	output logic [15:0]                      compare_b,
	output logic [15:0]                      compare_c,
	output logic [2:0]                       sector_index
);
	localparam int SB       = SINE_TABLE_BITS;
	localparam int BACK_LAT = SIN_LAT + 1 + DIV_STAGES + 2;
	localparam int T_W      = X_W;
	localparam int V_W      = X_W + 2;
	localparam logic [SB:0] N_K = (SB + 1)'(1) << SB;

	logic [BACK_LAT:0]   vld_s;
	logic [2:0]          sec_s [BACK_LAT+1];
	logic [SB-1:0]       k_s0;
	logic [SUMSQ_W-1:0]  sumsq_s0;

	logic [SB:0]         k1;
	logic [SB:0]         k2;
	logic [SIN_W-1:0]    sin1;
	logic [SIN_W-1:0]    sin2;

	logic [SUMSQ_W-1:0]  sv_s   [SQRT_STAGES];
	logic [19:0]         rem_s  [SQRT_STAGES];
	logic [MAG_W-1:0]    root_s [SQRT_STAGES];

	logic [MAG_W-1:0]    mag;
	logic [P_W-1:0]      pp;
	logic [P_W-1:0]      p_s9;
	logic [62:0]         qp;
	logic [Q_W-1:0]      q_s10;
	logic [Q_W-1:0]      q_s11;
	logic [63:0]         xp1;
	logic [63:0]         xp2;
	logic [X_W-1:0]      x1_s12;
	logic [X_W-1:0]      x2_s12;
	logic [T_W-1:0]      t1;
	logic [T_W-1:0]      t2;

	logic [T_W:0]        s12;
	logic [T_W:0]        full;
	logic [31:0]         t0;
	logic [T_W-1:0]      t1_s26;
	logic [T_W-1:0]      t2_s26;
	logic [T_W:0]        s12_s26;
	logic [30:0]         h0_s26;
	logic [15:0]         v0;
	logic [15:0]         v1;
	logic [15:0]         v2;
	logic [15:0]         v3;
	logic [15:0]         ca_s27;
	logic [15:0]         cb_s27;
	logic [15:0]         cc_s27;

	// Shift a time in Q16 ticks down to ticks and saturate to 16 bits.
	function automatic logic [15:0] sat_ticks(input logic [V_W-1:0] v);
		logic [15:0] r;
		if (|v[V_W-1:32]) begin
			r = 16'hFFFF;
		end else begin
			r = v[31:16];
		end
		return r;
	endfunction

	// Valid line through the whole back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[BACK_LAT-1:0], head_valid};
		end
	end

	// Entry stage and the sector line that follows the item.
	always_ff @(posedge clk) begin
		sec_s[0]  <= head_sector;
		k_s0      <= head_k;
		sumsq_s0  <= head_sumsq;
		for (int i = 1; i <= BACK_LAT; i++) begin
			sec_s[i] <= sec_s[i-1];
		end
	end

	// Two sine lanes: the far edge of the sector for t1, the near one for t2.
	assign k2 = {1'b0, k_s0};
	assign k1 = N_K - k2;

	svpwm_sine #(.SINE_TABLE_BITS(SB)) u_sine_t1 (
		.clk  (clk),
		.k    (k1),
		.sine (sin1)
	);

	svpwm_sine #(.SINE_TABLE_BITS(SB)) u_sine_t2 (
		.clk  (clk),
		.k    (k2),
		.sine (sin2)
	);

	// Integer square root, two result bits per stage.
	generate
		for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
			logic [SUMSQ_W-1:0] sv_in;
			logic [19:0]        rem_in;
			logic [MAG_W-1:0]   root_in;
			logic [SUMSQ_W-1:0] sv_nx;
			logic [19:0]        rem_nx;
			logic [MAG_W-1:0]   root_nx;

			if (j == 0) begin : g_first
				assign sv_in   = sumsq_s0;
				assign rem_in  = '0;
				assign root_in = '0;
			end else begin : g_next
				assign sv_in   = sv_s[j-1];
				assign rem_in  = rem_s[j-1];
				assign root_in = root_s[j-1];
			end

			always_comb begin : sqrt_step
				logic [19:0]        r;
				logic [19:0]        trial;
				logic [MAG_W-1:0]   q;
				logic [SUMSQ_W-1:0] w;
				r = rem_in;
				q = root_in;
				w = sv_in;
				for (int b = 0; b < 2; b++) begin
					r     = {r[17:0], w[SUMSQ_W-1 -: 2]};
					w     = {w[SUMSQ_W-3:0], 2'b00};
					trial = {2'b00, q, 2'b01};
					if (r >= trial) begin
						r = r - trial;
						q = {q[MAG_W-2:0], 1'b1};
					end else begin
						q = {q[MAG_W-2:0], 1'b0};
					end
				end
				rem_nx  = r;
				root_nx = q;
				sv_nx   = w;
			end

			always_ff @(posedge clk) begin
				sv_s[j]   <= sv_nx;
				rem_s[j]  <= rem_nx;
				root_s[j] <= root_nx;
			end
		end
	endgenerate

	// Clamp the magnitude, scale by the half period, then by sqrt(3).
	assign mag = (root_s[SQRT_STAGES-1] > max_ref_magnitude) ? max_ref_magnitude
	                                                         : root_s[SQRT_STAGES-1];
	assign pp  = P_W'(mag) * P_W'(half_period_ticks);
	assign qp  = 63'(p_s9) * 63'(SQRT3_Q30);

	always_ff @(posedge clk) begin
		p_s9  <= pp;
		q_s10 <= Q_W'(qp >> 30);
		q_s11 <= q_s10;
	end

	// Scale by the sines; the sine lanes are ready at the same stage.
	assign xp1 = 64'(q_s11) * 64'(sin1);
	assign xp2 = 64'(q_s11) * 64'(sin2);

	always_ff @(posedge clk) begin
		x1_s12 <= X_W'(xp1 >> 14);
		x2_s12 <= X_W'(xp2 >> 14);
	end

	// Divide both times by the DC link voltage.
	svpwm_div u_div_t1 (
		.clk      (clk),
		.dividend (x1_s12),
		.divisor  (udc),
		.quotient (t1)
	);

	svpwm_div u_div_t2 (
		.clk      (clk),
		.dividend (x2_s12),
		.divisor  (udc),
		.quotient (t2)
	);

	// Zero-vector time, floored at zero and halved.
	assign s12  = (T_W + 1)'(t1) + (T_W + 1)'(t2);
	assign full = (T_W + 1)'({half_period_ticks, 16'h0000});
	assign t0   = (s12 >= full) ? 32'd0 : 32'(full - s12);

	always_ff @(posedge clk) begin
		t1_s26  <= t1;
		t2_s26  <= t2;
		s12_s26 <= s12;
		h0_s26  <= t0[31:1];
	end

	// The four switching instants in ticks.
	assign v0 = sat_ticks(V_W'(h0_s26));
	assign v1 = sat_ticks(V_W'(h0_s26) + V_W'(t1_s26));
	assign v2 = sat_ticks(V_W'(h0_s26) + V_W'(t2_s26));
	assign v3 = sat_ticks(V_W'(h0_s26) + V_W'(s12_s26));

	// Assign the instants to the phases in the order of the sector.
	always_ff @(posedge clk) begin
		unique case (sec_s[BACK_LAT-1])
			3'd0: begin
				ca_s27 <= v0; cb_s27 <= v1; cc_s27 <= v3;
			end
			3'd1: begin
				ca_s27 <= v2; cb_s27 <= v0; cc_s27 <= v3;
			end
			3'd2: begin
				ca_s27 <= v3; cb_s27 <= v0; cc_s27 <= v1;
			end
			3'd3: begin
				ca_s27 <= v3; cb_s27 <= v2; cc_s27 <= v0;
			end
			3'd4: begin
				ca_s27 <= v1; cb_s27 <= v3; cc_s27 <= v0;
			end
			default: begin
				ca_s27 <= v0; cb_s27 <= v3; cc_s27 <= v2;
			end
		endcase
	end

	assign done         = vld_s[BACK_LAT];
	assign compare_a    = ca_s27;
	assign compare_b    = cb_s27;
	assign compare_c    = cc_s27;
	assign sector_index = sec_s[BACK_LAT];

endmodule

`default_nettype wire

// ===== sv/space_vector_pwm_timing.sv =====
// Space vector PWM timing: sector, dwell times and three phase compare values.
// An accepted item passes the front-end register, the queue and the back-end pipeline before done rises.
// Throughput: one item per cycle while busy is low; the pipelined dividers and sine lanes set the depth.
// busy never rises in operation: the back end drains the queue every cycle, so it holds at most one entry.
// Reset loads the register defaults and empties the queue and the pipeline.
// Results carry no backpressure: each one shows for a single cycle with done.
`default_nettype none

module space_vector_pwm_timing import svpwm_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int ANGLE_BITS      = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [15:0]        theta,
	input  wire logic signed [15:0] alpha_voltage,
	input  wire logic signed [15:0] beta_voltage,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [15:0]        wr_data,
	output logic                    done,
	output logic [15:0]             compare_a,
	output logic [15:0]             compare_b,
	output logic [15:0]             compare_c,
	output logic [2:0]              sector_index
);
	localparam int SB = SINE_TABLE_BITS;
	localparam int QW = 3 + SB + SUMSQ_W;

	logic [15:0]          dc_link_q;
	logic [15:0]          max_mag_q;
	logic [15:0]          half_period_q;
	logic [15:0]          udc;

	logic                 push;
	logic [2:0]           push_sector;
	logic [SB-1:0]        push_k;
	logic [SUMSQ_W-1:0]   push_sumsq;
	logic                 queue_afull;
	logic                 head_valid;
	logic [QW-1:0]        head_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_link_q     <= DC_LINK_RESET;
			max_mag_q     <= MAX_MAG_RESET;
			half_period_q <= HALF_PERIOD_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_DC_LINK:     dc_link_q     <= wr_data;
				REG_MAX_MAG:     max_mag_q     <= wr_data;
				REG_HALF_PERIOD: half_period_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// A DC link of zero divides as one.
	assign udc = (dc_link_q == '0) ? 16'd1 : dc_link_q;

	svpwm_front #(
		.SINE_TABLE_BITS (SB),
		.ANGLE_BITS      (ANGLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.theta         (theta),
		.alpha_voltage (alpha_voltage),
		.beta_voltage  (beta_voltage),
		.queue_afull   (queue_afull),
		.push          (push),
		.push_sector   (push_sector),
		.push_k        (push_k),
		.push_sumsq    (push_sumsq)
	);

	svpwm_queue #(
		.W     (QW),
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_sector, push_k, push_sumsq}),
		.afull      (queue_afull),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	svpwm_back #(
		.SINE_TABLE_BITS (SB)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head_sector       (head_data[QW-1 -: 3]),
		.head_k            (head_data[SUMSQ_W +: SB]),
		.head_sumsq        (head_data[SUMSQ_W-1:0]),
		.udc               (udc),
		.max_ref_magnitude (max_mag_q),
		.half_period_ticks (half_period_q),
		.done              (done),
		.compare_a         (compare_a),
		.compare_b         (compare_b),
		.compare_c         (compare_c),
		.sector_index      (sector_index)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the space vector PWM timing block.
`timescale 1ns / 1ps

module testbench;
	import svpwm_pkg::*;

	localparam int PERIOD_NS = 12;
	localparam int LATENCY = 29;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1880;

	typedef struct packed {
		logic [15:0] ca;
		logic [15:0] cb;
		logic [15:0] cc;
		logic [2:0]  sector;
	} timing_t;

	typedef struct {
		logic [15:0] theta;
		logic [15:0] alpha;
		logic [15:0] beta;
		bit          typed;
		timing_t     want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [15:0] theta;
	logic signed [15:0] alpha_voltage;
	logic signed [15:0] beta_voltage;
	logic wr_en;
	logic [1:0] wr_index;
	logic [15:0] wr_data;
	logic done;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic [2:0] sector_index;

	// Predictor copy of the configuration registers.
	logic [15:0] udc_reg;
	logic [15:0] max_mag_reg;
	logic [15:0] half_period_reg;

	timing_t expected_timings[$];
	int mismatches;
	int idle_cycles;
	int sender_idle_pct;
	bit timed_out;

	space_vector_pwm_timing dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.theta(theta), .alpha_voltage(alpha_voltage), .beta_voltage(beta_voltage),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .compare_a(compare_a), .compare_b(compare_b),
		.compare_c(compare_c), .sector_index(sector_index)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD_NS / 2) clk = ~clk;
	end

	// Integer square root by the digit-by-digit method.
	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Q30 sine of sixty degrees times k over 1024, by a truncated series.
	function automatic longint unsigned sector_sine_q30(longint unsigned k);
		longint unsigned divs[4];
		longint unsigned a;
		longint unsigned a2;
		longint unsigned h;
		divs = '{72, 42, 20, 6};
		a = (64'd1124419809 * k) >> 10;
		a2 = (a * a) >> 30;
		h = 64'd1 << 30;
		for (int i = 0; i < 4; i++)
			h = (64'd1 << 30) - (((a2 * h) >> 30) / divs[i]);
		return (a * h) >> 30;
	endfunction

	function automatic logic [15:0] tick_compare(longint unsigned v);
		v >>= 16;
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	// Predicts the compare values and sector for one reference.
	function automatic timing_t predict_timing(logic [15:0] th, logic signed [15:0] al,
			logic signed [15:0] be);
		longint unsigned six, sec, u, k, udc, mag, q, t1, t2, full, t0, h0;
		longint signed sa, sb;
		logic [15:0] v0, v1, v2, v3;
		timing_t r;
		six = 64'(th) * 6;
		sec = six >> 16;
		u = six - (sec << 16);
		k = u >> 6;
		udc = (udc_reg == 0) ? 1 : 64'(udc_reg);
		sa = al;
		sb = be;
		mag = isqrt(longint'(sa * sa + sb * sb));
		if (mag > max_mag_reg)
			mag = max_mag_reg;
		q = ((mag * half_period_reg) * 64'd1859775393) >> 30;
		t1 = ((q * sector_sine_q30(1024 - k)) >> 14) / udc;
		t2 = ((q * sector_sine_q30(k)) >> 14) / udc;
		full = 64'(half_period_reg) << 16;
		t0 = (t1 + t2 >= full) ? 0 : full - t1 - t2;
		h0 = t0 >> 1;
		v0 = tick_compare(h0);
		v1 = tick_compare(h0 + t1);
		v2 = tick_compare(h0 + t2);
		v3 = tick_compare(h0 + t1 + t2);
		case (sec)
			0: r = '{v0, v1, v3, 3'd0};
			1: r = '{v2, v0, v3, 3'd1};
			2: r = '{v3, v0, v1, 3'd2};
			3: r = '{v3, v2, v0, 3'd3};
			4: r = '{v1, v3, v0, 3'd4};
			default: r = '{v0, v3, v2, 3'd5};
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Result checker: each done transfer is matched with the oldest prediction.
	always @(posedge clk) begin
		timing_t w;
		if (arst_n && done) begin
			idle_cycles <= 0;
			if (expected_timings.size() == 0) begin
				report_mismatch("unexpected done", 16'd1, 16'd0);
			end else begin
				w = expected_timings.pop_front();
				if (compare_a !== w.ca) report_mismatch("compare_a", compare_a, w.ca);
				if (compare_b !== w.cb) report_mismatch("compare_b", compare_b, w.cb);
				if (compare_c !== w.cc) report_mismatch("compare_c", compare_c, w.cc);
				if (sector_index !== w.sector)
					report_mismatch("sector_index", 16'(sector_index), 16'(w.sector));
			end
		end else if (arst_n && start && !busy) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("space_vector_pwm_timing regression: fail");
			$finish;
		end
	end

	task automatic write_reg(reg_index_t idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_DC_LINK: udc_reg = val;
			REG_MAX_MAG: max_mag_reg = val;
			default: half_period_reg = val;
		endcase
	endtask

	// Wait for all predicted results plus the pipeline depth before a write.
	task automatic drain_pipeline();
		while (expected_timings.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Offers one item from the falling edge; returns after its transfer.
	task automatic send_reference(logic [15:0] th, logic [15:0] al, logic [15:0] be,
			bit typed, timing_t want);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		theta <= th;
		alpha_voltage <= al;
		beta_voltage <= be;
		do
			@(posedge clk);
		while (busy);
		expected_timings.push_back(typed ? want : predict_timing(th, al, be));
		@(negedge clk);
	endtask

	task automatic random_phase(int count);
		logic [15:0] th, al, be;
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(9);
			th = $urandom;
			al = $urandom;
			be = $urandom;
			// Mostly moderate magnitudes so the clamp and overmodulation both occur.
			if (mode < 6) begin
				al = 16'($signed(15'($urandom)) >>> $urandom_range(5));
				be = 16'($signed(15'($urandom)) >>> $urandom_range(5));
			end else if (mode == 6) begin
				th = 16'(($urandom_range(5) * 65536 + 5) / 6) + 16'($urandom_range(3)) - 16'd1;
			end
			send_reference(th, al, be, 1'b0, '0);
			if (i == count / 2) begin
				start <= 1'b0;
				while (expected_timings.size() != 0)
					@(negedge clk);
			end
		end
		start <= 1'b0;
	endtask

	stim_row_t directed[] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'd2100, 16'd2100, 16'd2100, 3'd0}},
		'{16'hFFFF, 16'h0000, 16'h0000, 1'b1, '{16'd2100, 16'd2100, 16'd2100, 3'd5}},
		'{16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, '0},
		'{16'h0000, 16'h8000, 16'h8000, 1'b0, '0},
		'{16'h2AAB, 16'h8000, 16'h7FFF, 1'b0, '0},
		'{16'h2AAA, 16'h1000, 16'hF000, 1'b0, '0},
		'{16'h5555, 16'h4000, 16'h0000, 1'b0, '0},
		'{16'h8000, 16'h0000, 16'h4000, 1'b0, '0},
		'{16'hAAAB, 16'h3000, 16'h3000, 1'b0, '0},
		'{16'hD555, 16'hC000, 16'h2000, 1'b0, '0},
		'{16'hF000, 16'h0001, 16'hFFFF, 1'b0, '0},
		'{16'h1555, 16'h5555, 16'hAAAA, 1'b0, '0},
		'{16'h6000, 16'h2000, 16'h2000, 1'b0, '0},
		'{16'hB000, 16'hFFFF, 16'h0001, 1'b0, '0}
	};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		theta = '0;
		alpha_voltage = '0;
		beta_voltage = '0;
		wr_en = 1'b0;
		wr_index = REG_DC_LINK;
		wr_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		sender_idle_pct = 11;
		udc_reg = DC_LINK_RESET;
		max_mag_reg = MAX_MAG_RESET;
		half_period_reg = HALF_PERIOD_RESET;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows at reset settings.
		foreach (directed[i])
			send_reference(directed[i].theta, directed[i].alpha, directed[i].beta,
				directed[i].typed, directed[i].want);
		start <= 1'b0;

		// Zero half period forces all compares to zero.
		drain_pipeline();
		write_reg(REG_HALF_PERIOD, 16'd0);
		send_reference(16'h1234, 16'h7FFF, 16'h7FFF, 1'b1, '{16'd0, 16'd0, 16'd0, 3'd0});
		start <= 1'b0;

		// Zero DC link, extreme clamp and period.
		drain_pipeline();
		write_reg(REG_DC_LINK, 16'd0);
		write_reg(REG_MAX_MAG, 16'hFFFF);
		write_reg(REG_HALF_PERIOD, 16'hFFFF);
		random_phase(20);

		drain_pipeline();
		write_reg(REG_DC_LINK, 16'hFFFF);
		write_reg(REG_MAX_MAG, 16'd0);
		write_reg(REG_HALF_PERIOD, 16'd1);
		random_phase(40);

		drain_pipeline();
		write_reg(REG_DC_LINK, DC_LINK_RESET);
		write_reg(REG_MAX_MAG, MAX_MAG_RESET);
		write_reg(REG_HALF_PERIOD, HALF_PERIOD_RESET);
		random_phase(RANDOM_ITEMS / 3);

		drain_pipeline();
		sender_idle_pct = 58;
		write_reg(REG_DC_LINK, 16'($urandom_range(65535, 1)));
		write_reg(REG_MAX_MAG, 16'($urandom));
		write_reg(REG_HALF_PERIOD, 16'($urandom_range(65535, 1)));
		random_phase(RANDOM_ITEMS / 3);

		drain_pipeline();
		sender_idle_pct = 0;
		write_reg(REG_DC_LINK, 16'd1000);
		write_reg(REG_MAX_MAG, 16'd20000);
		write_reg(REG_HALF_PERIOD, 16'd3000);
		random_phase(RANDOM_ITEMS / 3);

		// Drain and settle.
		while (expected_timings.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (mismatches == 0 && expected_timings.size() == 0)
			$display("space_vector_pwm_timing regression: pass");
		else
			$display("space_vector_pwm_timing regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/svpwm_pkg.sv
sv/svpwm_queue.sv
sv/svpwm_front.sv
sv/svpwm_sine.sv
sv/svpwm_div.sv
sv/svpwm_back.sv
sv/space_vector_pwm_timing.sv
test/testbench.sv
